@@ hdl/trd_pkg.sv @@
// Shared types and constants for the touch report decode and rotate unit.
// No dependencies.
package trd_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned IdW    = 4;
  localparam int unsigned PosW   = 4;
  localparam int unsigned CfgW   = 12;
  localparam int unsigned OutW   = 64;

  // byte offsets within the report
  localparam logic [PosW-1:0] POS_COUNT = 4'd0;
  localparam logic [PosW-1:0] POS_AXH   = 4'd1;
  localparam logic [PosW-1:0] POS_AXL   = 4'd2;
  localparam logic [PosW-1:0] POS_AYH   = 4'd3;
  localparam logic [PosW-1:0] POS_AYL   = 4'd4;
  localparam logic [PosW-1:0] POS_BXH   = 4'd7;
  localparam logic [PosW-1:0] POS_BXL   = 4'd8;
  localparam logic [PosW-1:0] POS_BYH   = 4'd9;
  localparam logic [PosW-1:0] POS_LAST  = 4'd10;

  // input kind codes
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_ABORT = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_ROTATION = 2'd0;
  localparam logic [1:0] REG_MAP      = 2'd1;
  localparam logic [1:0] REG_XMAX     = 2'd2;
  localparam logic [1:0] REG_YMAX     = 2'd3;

  localparam logic [1:0]        ROT_RESET  = 2'd1;
  localparam logic              MAP_RESET  = 1'b1;
  localparam logic [CoordW-1:0] XMAX_RESET = 12'd319;
  localparam logic [CoordW-1:0] YMAX_RESET = 12'd479;

  typedef struct packed {
    logic [1:0]        rotation;
    logic              map_to_screen;
    logic [CoordW-1:0] panel_x_max;
    logic [CoordW-1:0] panel_y_max;
  } cfg_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [IdW-1:0]    id;
  } pt_t;

  // one decoded report as queued between front and back
  typedef struct packed {
    logic       ok;
    logic [1:0] count;
    pt_t        a;
    pt_t        b;
  } rec_t;

  // result layout, lowest field last
  typedef struct packed {
    logic [4:0]        pad;
    logic [IdW-1:0]    second_id;
    logic [CoordW-1:0] second_y;
    logic [CoordW-1:0] second_x;
    logic [IdW-1:0]    first_id;
    logic [CoordW-1:0] first_y;
    logic [CoordW-1:0] first_x;
    logic [1:0]        touch_count;
    logic              touched;
  } res_t;

endpackage

@@ hdl/trd_front.sv @@
// Front end: collects report bytes and emits one decoded record per burst or abort.
// Depends on trd_pkg.
module trd_front import trd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       kind,
  input  logic [7:0] report_byte,
  input  logic       full,
  output logic       push,
  output rec_t       rec
);

  logic [PosW-1:0] pos;
  logic [3:0]      cnt_nib;
  logic [3:0]      axh, ayh, aid, bxh, byh, bid;
  logic [7:0]      axl, ayl, bxl;
  logic            xfer;

  assign in_ready = !full;
  assign xfer     = in_valid && in_ready;
  assign push     = xfer && (kind == KIND_ABORT || pos >= POS_LAST);

  always_comb begin
    rec         = '0;
    rec.ok      = (kind == KIND_BYTE) && (cnt_nib == 4'd1 || cnt_nib == 4'd2);
    rec.count   = cnt_nib[1:0];
    rec.a.x     = {axh, axl};
    rec.a.y     = {ayh, ayl};
    rec.a.id    = aid;
    rec.b.x     = {bxh, bxl};
    rec.b.y     = {byh, report_byte};
    rec.b.id    = bid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (xfer) begin
      if (kind == KIND_ABORT || pos >= POS_LAST) pos <= '0;
      else pos <= pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer && kind == KIND_BYTE) begin
      case (pos)
        POS_COUNT: cnt_nib <= report_byte[3:0];
        POS_AXH:   axh <= report_byte[3:0];
        POS_AXL:   axl <= report_byte;
        POS_AYH:   begin
          ayh <= report_byte[3:0];
          aid <= report_byte[7:4];
        end
        POS_AYL:   ayl <= report_byte;
        POS_BXH:   bxh <= report_byte[3:0];
        POS_BXL:   bxl <= report_byte;
        POS_BYH:   begin
          byh <= report_byte[3:0];
          bid <= report_byte[7:4];
        end
        default:   ;
      endcase
    end
  end

endmodule

@@ hdl/trd_fifo.sv @@
// Short record queue between front and back.
// Depends on trd_pkg.
module trd_fifo import trd_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t wr_rec,
  output logic full,
  input  logic pop,
  output logic rd_valid,
  output rec_t rd_rec
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  rec_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == CntW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_rec   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_rec;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !rd_valid))
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CntW'(DEPTH))
    else $error("queue count out of range");

endmodule

@@ hdl/trd_back.sv @@
// Back end: orders points by finger id, applies screen mapping when enabled, holds the result.
// Depends on trd_pkg.
module trd_back import trd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  logic            rec_valid,
  input  rec_t            rec,
  output logic            rec_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [OutW-1:0] out_data
);

  res_t res, res_next;
  pt_t  first_pt, second_pt, first_m, second_m;

  function automatic logic [CoordW-1:0] mirror(logic [CoordW-1:0] v, logic [CoordW-1:0] m);
    return (v <= m) ? (m - v) : '0;
  endfunction

  function automatic pt_t map_pt(pt_t p, cfg_t c);
    pt_t q;
    q = p;
    case (c.rotation)
      2'd0:    ;
      2'd1:    begin
        q.x = p.y;
        q.y = mirror(p.x, c.panel_x_max);
      end
      2'd2:    begin
        q.x = mirror(p.x, c.panel_x_max);
        q.y = mirror(p.y, c.panel_y_max);
      end
      default: begin
        q.x = mirror(p.y, c.panel_y_max);
        q.y = p.x;
      end
    endcase
    return q;
  endfunction

  assign rec_pop  = rec_valid && (!out_valid || out_ready);
  assign out_data = res;

  always_comb begin
    first_pt  = rec.a;
    second_pt = '0;
    if (rec.count == 2'd2) begin
      if (rec.a.id <= rec.b.id) begin
        second_pt = rec.b;
      end else begin
        first_pt  = rec.b;
        second_pt = rec.a;
      end
    end
    first_m  = cfg.map_to_screen ? map_pt(first_pt, cfg) : first_pt;
    second_m = second_pt;
    if (cfg.map_to_screen && rec.count == 2'd2) second_m = map_pt(second_pt, cfg);

    res_next = '0;
    if (rec.ok) begin
      res_next.touched     = 1'b1;
      res_next.touch_count = rec.count;
      res_next.first_x     = first_m.x;
      res_next.first_y     = first_m.y;
      res_next.first_id    = first_m.id;
      res_next.second_x    = second_m.x;
      res_next.second_y    = second_m.y;
      res_next.second_id   = second_m.id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) res <= res_next;
  end

  a_zero_when_untouched: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.touched |-> res == '0)
    else $error("untouched result not all zero");
  a_count_when_touched: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.touched |-> (res.touch_count == 2'd1 || res.touch_count == 2'd2))
    else $error("touched result with bad count");
  a_single_second_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.touch_count == 2'd1 |->
      res.second_x == '0 && res.second_y == '0 && res.second_id == '0)
    else $error("single touch with second point set");

endmodule

@@ hdl/touch_report_decode_rotate_unit.sv @@
// Top level of the touch report decode and rotate unit: config registers,
// front end, record queue and back end. Depends on trd_pkg, trd_front, trd_fifo, trd_back.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_tvalid/s_tready  | s_tdata = report_byte, s_tuser = kind
//   m_      | out | m_tvalid/m_tready  | m_tdata = result fields
//   cfg_    | in  | cfg_we             | cfg_index, cfg_data
//
// One input transfer per cycle while the queue is not full. A result is offered after the
// eleventh byte or an abort is accepted (queue write, then output register).
// Reset restores the register defaults and empties the queue; no clearing pass.
// s_tready drops only while the QUEUE_DEPTH-entry record queue is full, which
// happens when m_tready is held low across several completed reports.
module touch_report_decode_rotate_unit import trd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,   // [7:0] report_byte
  input  logic            s_tuser,   // [0] kind
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [OutW-1:0] m_tdata,   // touched, touch_count, first_x, first_y, first_id,
                                     // second_x, second_y, second_id, zero pad
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [CfgW-1:0] cfg_data
);

  cfg_t cfg;
  rec_t f_rec, q_rec;
  logic push, full, pop, q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotation      <= ROT_RESET;
      cfg.map_to_screen <= MAP_RESET;
      cfg.panel_x_max   <= XMAX_RESET;
      cfg.panel_y_max   <= YMAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROTATION: cfg.rotation      <= cfg_data[1:0];
        REG_MAP:      cfg.map_to_screen <= cfg_data[0];
        REG_XMAX:     cfg.panel_x_max   <= cfg_data;
        REG_YMAX:     cfg.panel_y_max   <= cfg_data;
        default:      ;
      endcase
    end
  end

  trd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .kind        (s_tuser),
    .report_byte (s_tdata),
    .full        (full),
    .push        (push),
    .rec         (f_rec)
  );

  trd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_rec   (f_rec),
    .full     (full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_rec   (q_rec)
  );

  trd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rec_valid (q_valid),
    .rec       (q_rec),
    .rec_pop   (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
